// ===== design/repeating_timer_bank_unit_macros.svh =====
// Assertion macros used by the timer bank checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef REPEATING_TIMER_BANK_UNIT_MACROS_SVH
`define REPEATING_TIMER_BANK_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define RTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define RTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rtb_pkg.sv =====
// Shared types and constants of the repeating timer bank.
// No dependencies; used by the control unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rtb_pkg;

	// command codes of an input item
	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_ALLOC   = 3'd1,
		CMD_DEALLOC = 3'd2,
		CMD_SETUP   = 3'd3,
		CMD_START   = 3'd4,
		CMD_STOP    = 3'd5,
		CMD_COLLECT = 3'd6
	} cmd_t;

	// status codes of a result item
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NONE_FREE   = 3'd1,
		ST_NOT_ALLOC   = 3'd2,
		ST_INVALID_CB  = 3'd3,
		ST_BAD_ID      = 3'd4
	} status_t;

	localparam logic [7:0] REPEAT_FOREVER = 8'hFF;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	// configuration register index (paddr[2])
	localparam logic REG_IDX_INV_CODE = 1'b0;

	// one input item, last field in the low bits
	typedef struct packed {
		logic [7:0]  msg_options;
		logic [7:0]  msg_type;
		logic [7:0]  repeat_count;
		logic [31:0] timeout;
		logic [2:0]  timer_id;
		logic [2:0]  cmd;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	// one result item, status in the low bits
	typedef struct packed {
		logic        last;
		logic        wake;
		logic [7:0]  out_msg_options;
		logic [7:0]  out_msg_type;
		logic [2:0]  result_timer;
		logic [2:0]  status;
	} result_t;

	localparam int RES_DATA_W = $bits(result_t) - 1;

	// per-timer record held in the state memory
	typedef struct packed {
		logic [31:0] down_counter;
		logic [31:0] reload_value;
		logic [7:0]  repeats_left;
		logic [7:0]  callback_type;
		logic [7:0]  callback_options;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

endpackage

`default_nettype wire

// ===== design/rtb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/rtb_ctrl.sv =====
// Command sequencer of the timer bank: marks, sweeps and read-modify-write
// of the timer records. Depends on rtb_pkg; drives an external rtb_ram.
`timescale 1ns / 1ps
`default_nettype none

module rtb_ctrl
	import rtb_pkg::*;
#(
	parameter int NUM_TIMERS = 8
) (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire logic                                              in_valid,
	output logic                                                   in_ready,
	input  wire item_t                                             in_item,
	input  wire logic [7:0]                                        inv_code,
	output logic                                                   res_valid,
	input  wire logic                                              res_ready,
	output result_t                                                res,
	output logic                                                   ram_re,
	output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] ram_raddr,
	input  wire rec_t                                              ram_rdata,
	output logic                                                   ram_we,
	output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] ram_waddr,
	output rec_t                                                   ram_wdata
);

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int PW = $clog2(NUM_TIMERS + 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MOD   = 8'b0000_0010,
		S_TICK  = 8'b0000_0100,
		S_ALLOC = 8'b0000_1000,
		S_COL   = 8'b0001_0000,
		S_CWAIT = 8'b0010_0000,
		S_EMIT  = 8'b0100_0000,
		S_SPARE = 8'b1000_0000
	} state_t;

	state_t               state_q;
	item_t                item_q;
	result_t              res_q;
	logic [PW-1:0]        ptr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 wake_q;
	logic                 ret_col_q;
	logic                 rd_v_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic [NUM_TIMERS-1:0] alloc_q;
	logic [NUM_TIMERS-1:0] run_q;
	logic [NUM_TIMERS-1:0] exp_q;
	logic [NUM_TIMERS-1:0] written_q;

	logic                 accept;
	logic [AW-1:0]        id_idx;
	logic                 id_bad;
	logic [AW-1:0]        ptr_idx;
	logic                 ptr_end;
	rec_t                 rd_rec;
	rec_t                 tk_rec;
	logic                 tk_zero;
	logic                 tk_stop;
	logic                 tk_hit;
	logic [NUM_TIMERS-1:0] later;
	logic                 col_last;
	logic                 start_ok;
	logic [AW-1:0]        q_idx;
	result_t              res_d;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign id_idx    = AW'(in_item.timer_id);
	assign id_bad    = 32'(in_item.timer_id) >= 32'(NUM_TIMERS);
	assign q_idx     = AW'(item_q.timer_id);
	assign ptr_idx   = ptr_q[AW-1:0];
	assign ptr_end   = (ptr_q == PW'(NUM_TIMERS));
	assign res_valid = (state_q == S_EMIT);
	assign res       = res_q;

	// entries never written read as zero
	assign rd_rec = written_q[rd_idx_s1] ? ram_rdata : '0;

	// one tick of the record read last cycle
	always_comb begin
		tk_rec  = rd_rec;
		tk_zero = 1'b0;
		tk_stop = 1'b0;
		if (rd_rec.down_counter != '0) begin
			tk_rec.down_counter = rd_rec.down_counter - 32'd1;
		end
		if (tk_rec.down_counter == '0) begin
			tk_zero = 1'b1;
			priority if (rd_rec.repeats_left == REPEAT_FOREVER) begin
				tk_rec.down_counter = rd_rec.reload_value;
			end else if (rd_rec.repeats_left != '0) begin
				tk_rec.down_counter = rd_rec.reload_value;
				tk_rec.repeats_left = rd_rec.repeats_left - 8'd1;
			end else begin
				tk_stop = 1'b1;
			end
		end
	end

	assign tk_hit   = rd_v_s1 && run_q[rd_idx_s1];
	assign start_ok = (rd_rec.callback_type != inv_code);

	// expired timers above the one being reported
	always_comb begin
		for (int i = 0; i < NUM_TIMERS; i++) begin
			later[i] = exp_q[i] && (PW'(i) > ptr_q);
		end
	end

	assign col_last = ((cnt_q + CNT_W'(1)) == CNT_W'(MAX_RESULTS)) || (later == '0);

	// memory read and write requests
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = id_idx;
		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = tk_rec;
		unique case (state_q)
			S_IDLE: begin
				// read the addressed record only for setup and start
				ram_re = accept && (cmd_t'(in_item.cmd) == CMD_SETUP
					|| cmd_t'(in_item.cmd) == CMD_START);
			end
			S_TICK: begin
				ram_re    = !ptr_end;
				ram_raddr = ptr_idx;
				ram_we    = tk_hit;
			end
			S_COL: begin
				ram_re    = !ptr_end && exp_q[ptr_idx];
				ram_raddr = ptr_idx;
			end
			S_MOD: begin
				ram_wdata = rd_rec;
				if (cmd_t'(item_q.cmd) == CMD_SETUP) begin
					ram_we                     = 1'b1;
					ram_wdata.reload_value     = item_q.timeout;
					ram_wdata.repeats_left     = item_q.repeat_count;
					ram_wdata.callback_type    = item_q.msg_type;
					ram_wdata.callback_options = item_q.msg_options;
				end else begin
					ram_we                 = start_ok;
					ram_wdata.down_counter = rd_rec.reload_value;
				end
			end
			default: begin
			end
		endcase
	end

	// read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= ram_re;
		end
	end

	// next result item
	always_comb begin
		res_d = res_q;
		unique case (state_q)
			S_IDLE: begin
				res_d              = '0;
				res_d.status       = ST_OK;
				res_d.result_timer = in_item.timer_id;
				res_d.last         = 1'b1;
				if (id_bad) begin
					res_d.status = ST_BAD_ID;
				end else if (cmd_t'(in_item.cmd) != CMD_STOP && !alloc_q[id_idx]) begin
					res_d.status = ST_NOT_ALLOC;
				end
			end
			S_MOD: begin
				if (cmd_t'(item_q.cmd) == CMD_START && !start_ok) begin
					res_d.status = ST_INVALID_CB;
				end
			end
			S_TICK: begin
				res_d        = '0;
				res_d.status = ST_OK;
				res_d.wake   = wake_q;
				res_d.last   = 1'b1;
			end
			S_ALLOC: begin
				res_d        = '0;
				res_d.status = ST_OK;
				res_d.last   = 1'b1;
				if (ptr_end) begin
					res_d.status = ST_NONE_FREE;
				end else begin
					res_d.result_timer = 3'(ptr_q);
				end
			end
			S_CWAIT: begin
				res_d                 = '0;
				res_d.status          = ST_OK;
				res_d.result_timer    = 3'(ptr_q);
				res_d.out_msg_type    = rd_rec.callback_type;
				res_d.out_msg_options = rd_rec.callback_options;
				res_d.last            = col_last;
			end
			default: begin
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_idx_s1 <= ram_raddr;
		end
		if (accept) begin
			item_q <= in_item;
		end
		res_q <= res_d;
	end

	// sequencer and marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ptr_q     <= '0;
			cnt_q     <= '0;
			wake_q    <= 1'b0;
			ret_col_q <= 1'b0;
			alloc_q   <= '0;
			run_q     <= '0;
			exp_q     <= '0;
			written_q <= '0;
		end else begin
			if (ram_we) begin
				written_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					ptr_q     <= '0;
					cnt_q     <= '0;
					wake_q    <= 1'b0;
					ret_col_q <= 1'b0;
					if (accept) begin
						unique case (in_item.cmd)
							CMD_TICK:    state_q <= S_TICK;
							CMD_ALLOC:   state_q <= S_ALLOC;
							CMD_COLLECT: state_q <= S_COL;
							CMD_STOP: begin
								state_q <= S_EMIT;
								if (!id_bad) begin
									run_q[id_idx] <= 1'b0;
									exp_q[id_idx] <= 1'b0;
								end
							end
							CMD_DEALLOC: begin
								state_q <= S_EMIT;
								if (!id_bad && alloc_q[id_idx]) begin
									alloc_q[id_idx] <= 1'b0;
									run_q[id_idx]   <= 1'b0;
									exp_q[id_idx]   <= 1'b0;
								end
							end
							CMD_SETUP, CMD_START: begin
								if (!id_bad && alloc_q[id_idx]) begin
									state_q <= S_MOD;
								end else begin
									state_q <= S_EMIT;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_MOD: begin
					state_q <= S_EMIT;
					if (cmd_t'(item_q.cmd) == CMD_START && start_ok) begin
						run_q[q_idx] <= 1'b1;
						exp_q[q_idx] <= 1'b0;
					end
				end
				S_TICK: begin
					if (!ptr_end) begin
						ptr_q <= ptr_q + PW'(1);
					end
					if (tk_hit && tk_zero) begin
						exp_q[rd_idx_s1] <= 1'b1;
						wake_q           <= 1'b1;
						if (tk_stop) begin
							run_q[rd_idx_s1] <= 1'b0;
						end
					end
					if (ptr_end && !rd_v_s1) begin
						state_q <= S_EMIT;
					end
				end
				S_ALLOC: begin
					if (ptr_end) begin
						state_q <= S_EMIT;
					end else if (!alloc_q[ptr_idx]) begin
						alloc_q[ptr_idx] <= 1'b1;
						state_q          <= S_EMIT;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				S_COL: begin
					if (ptr_end) begin
						state_q <= S_IDLE;
					end else if (exp_q[ptr_idx]) begin
						state_q <= S_CWAIT;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				S_CWAIT: begin
					exp_q[ptr_idx] <= 1'b0;
					cnt_q          <= cnt_q + CNT_W'(1);
					ptr_q          <= ptr_q + PW'(1);
					ret_col_q      <= !col_last;
					state_q        <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= ret_col_q ? S_COL : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/repeating_timer_bank_unit.sv =====
// Repeating timer bank, top level: stream ports, APB register, output item
// register. Depends on rtb_pkg, rtb_ctrl and rtb_ram.
`timescale 1ns / 1ps
`default_nettype none

// A bank of NUM_TIMERS timers whose records (counter, period, repeat count,
// message) sit in one synchronous RAM; allocated, running and expired marks
// are flip-flops. The block works on one item at a time and takes the next
// item as soon as the previous result has moved to the output register, even
// while that result waits for m_tready. A tick sweeps the RAM one timer per
// cycle with a read-modify-write. Allocate scans the marks one timer per
// cycle. Collect scans one timer per cycle and, for each reported timer,
// waits for its RAM read and then for the output; it reports at most
// eight timers and gives no item when nothing has expired. Setup and start
// pass through a read-modify-write state (not for a bad id or a timer that
// is not allocated); deallocate and stop go straight to their result.
// No clearing pass follows reset.
module repeating_timer_bank_unit
	import rtb_pkg::*;
#(
	parameter int NUM_TIMERS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input item: cmd[2:0], timer_id[5:3], timeout[37:6], repeat_count[45:38],
	// msg_type[53:46], msg_options[61:54], zero pad[63:62]
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,
	// result item: status[2:0], result_timer[5:3], out_msg_type[13:6],
	// out_msg_options[21:14], wake[22], zero pad[23]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [7:0] inv_code_q;
	item_t      in_item;
	result_t    res;
	logic       res_valid;
	logic       res_ready;
	result_t    out_q;
	logic       out_valid_q;
	logic       ram_re;
	logic       ram_we;
	logic [AW-1:0] ram_raddr;
	logic [AW-1:0] ram_waddr;
	rec_t       ram_rdata;
	rec_t       ram_wdata;
	logic [REC_W-1:0] ram_rdata_raw;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_code_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_IDX_INV_CODE) begin
			inv_code_q <= pwdata[7:0];
		end
	end
	assign prdata = (psel && paddr[2] == REG_IDX_INV_CODE) ? {24'd0, inv_code_q} : '0;

	assign in_item = item_t'(s_tdata[ITEM_W-1:0]);

	rtb_ctrl #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.inv_code  (inv_code_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	rtb_ram #(
		.WIDTH(REC_W),
		.DEPTH(NUM_TIMERS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);
	assign ram_rdata = rec_t'(ram_rdata_raw);

	// output item register
	assign res_ready = !out_valid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q[RES_DATA_W-1:0]};
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

// ===== design/rtb_checker.sv =====
// Port-level checks of the repeating timer bank, bound to the top level.
// Depends on repeating_timer_bank_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "repeating_timer_bank_unit_macros.svh"

module rtb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tlast
);

	// hold a stalled result item
	`RTB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item dropped while stalled")

	// status stays within its defined codes
	`RTB_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[2:0] <= 3'd4, "undefined status code")

	// only collect items continue a run
	`RTB_ASSERT_NOW(a_run_ok, m_tvalid && !m_tlast, m_tdata[2:0] == 3'd0 && !m_tdata[22], "open run on a non-collect item")

	// a wake item carries nothing else
	`RTB_ASSERT_NOW(a_wake_clean, m_tvalid && m_tdata[22], m_tdata[21:0] == 22'd0 && m_tlast, "wake item with stray fields")

endmodule

bind repeating_timer_bank_unit rtb_checker u_rtb_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for repeating_timer_bank_unit: directed and random command
// streams with a cycle-free prediction of every result item and APB writes in between.
// Depends on rtb_pkg and the repeating_timer_bank_unit RTL.
`timescale 1ns / 1ps

module tb
	import rtb_pkg::*;
();

	localparam int NUM_TIMERS = 8;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic [2:0] ADDR_INV_CODE = {REG_IDX_INV_CODE, 2'b00};
	// drain time for items that give no result (collect of nothing, unused command)
	localparam int QUIET_CYCLES = 4 * NUM_TIMERS + 16;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_PHASES = 4;
	localparam int ITEMS_PER_PHASE = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // cmd, timer_id, timeout, repeat_count, msg_type, msg_options
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // status, result_timer, out_msg_type, out_msg_options, wake
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predicted bank state
	bit          owned [NUM_TIMERS];
	bit          running [NUM_TIMERS];
	bit          fired [NUM_TIMERS];
	logic [31:0] remaining [NUM_TIMERS];
	logic [31:0] period [NUM_TIMERS];
	logic [7:0]  repeats [NUM_TIMERS];
	logic [7:0]  cb_type [NUM_TIMERS];
	logic [7:0]  cb_opts [NUM_TIMERS];
	logic [7:0]  inv_code = '0;

	result_t     awaited_results[$];
	int          mismatches = 0;
	bit          calm = 1'b0;
	int          sink_wait = 0;
	int          idle_cycles = 0;

	repeating_timer_bank_unit #(.NUM_TIMERS(NUM_TIMERS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Work out the result items of one accepted item and advance the bank state
	function automatic void compute_bank_results(input item_t it);
		result_t r;
		int ids [MAX_RESULTS];
		int nrep;
		logic [2:0] id;
		r = '0;
		r.status = ST_OK;
		r.last = 1'b1;
		id = it.timer_id;
		case (it.cmd)
			CMD_TICK: begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (running[i]) begin
						if (remaining[i] != 0)
							remaining[i]--;
						if (remaining[i] == 0) begin
							if (repeats[i] == REPEAT_FOREVER) begin
								remaining[i] = period[i];
							end else if (repeats[i] != 0) begin
								remaining[i] = period[i];
								repeats[i]--;
							end else begin
								running[i] = 1'b0;
							end
							fired[i] = 1'b1;
							r.wake = 1'b1;
						end
					end
				end
				awaited_results.push_back(r);
			end
			CMD_ALLOC: begin
				r.status = ST_NONE_FREE;
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (r.status == ST_NONE_FREE && !owned[i]) begin
						owned[i] = 1'b1;
						r.status = ST_OK;
						r.result_timer = 3'(i);
					end
				end
				awaited_results.push_back(r);
			end
			CMD_COLLECT: begin
				nrep = 0;
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (fired[i] && nrep < MAX_RESULTS) begin
						ids[nrep] = i;
						fired[i] = 1'b0;
						nrep++;
					end
				end
				for (int k = 0; k < nrep; k++) begin
					r.result_timer = 3'(ids[k]);
					r.out_msg_type = cb_type[ids[k]];
					r.out_msg_options = cb_opts[ids[k]];
					r.last = (k == nrep - 1);
					awaited_results.push_back(r);
				end
			end
			CMD_UNUSED: ;
			default: begin
				// deallocate, setup, start and stop address one timer
				r.result_timer = id;
				if (id >= NUM_TIMERS) begin
					r.status = ST_BAD_ID;
				end else if (it.cmd == CMD_STOP) begin
					running[id] = 1'b0;
					fired[id] = 1'b0;
				end else if (!owned[id]) begin
					r.status = ST_NOT_ALLOC;
				end else if (it.cmd == CMD_DEALLOC) begin
					owned[id] = 1'b0;
					running[id] = 1'b0;
					fired[id] = 1'b0;
				end else if (it.cmd == CMD_SETUP) begin
					period[id] = it.timeout;
					repeats[id] = it.repeat_count;
					cb_type[id] = it.msg_type;
					cb_opts[id] = it.msg_options;
				end else if (cb_type[id] == inv_code) begin
					r.status = ST_INVALID_CB;
				end else begin
					running[id] = 1'b1;
					fired[id] = 1'b0;
					remaining[id] = period[id];
				end
				awaited_results.push_back(r);
			end
		endcase
	endfunction

	function automatic item_t make_item(input logic [2:0] cmd, input logic [2:0] id,
			input logic [31:0] timeout, input logic [7:0] rep,
			input logic [7:0] mtype, input logic [7:0] mopt);
		item_t it;
		it.cmd = cmd;
		it.timer_id = id;
		it.timeout = timeout;
		it.repeat_count = rep;
		it.msg_type = mtype;
		it.msg_options = mopt;
		return it;
	endfunction

	// Mostly well-formed traffic on allocated timers with short periods, some noise
	function automatic item_t draw_random_item();
		item_t it;
		int pick;
		int pool [$];
		it = make_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom(),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		pick = $urandom_range(0, 99);
		if (pick < 34)
			it.cmd = CMD_TICK;
		else if (pick < 44)
			it.cmd = CMD_COLLECT;
		else if (pick < 54)
			it.cmd = CMD_ALLOC;
		else if (pick < 62)
			it.cmd = CMD_DEALLOC;
		else if (pick < 78)
			it.cmd = CMD_SETUP;
		else if (pick < 91)
			it.cmd = CMD_START;
		else if (pick < 97)
			it.cmd = CMD_STOP;
		else
			it.cmd = CMD_UNUSED;
		for (int i = 0; i < NUM_TIMERS; i++)
			if (owned[i])
				pool.push_back(i);
		if (pool.size() != 0 && $urandom_range(0, 4) != 0)
			it.timer_id = 3'(pool[$urandom_range(0, pool.size() - 1)]);
		if ($urandom_range(0, 9) != 0)
			it.timeout = $urandom_range(0, 4);
		pick = $urandom_range(0, 19);
		if (pick < 5)
			it.repeat_count = REPEAT_FOREVER;
		else if (pick < 17)
			it.repeat_count = 8'($urandom_range(0, 3));
		if ($urandom_range(0, 7) == 0)
			it.msg_type = inv_code;
		return it;
	endfunction

	// Offer one item, wait for the handshake, then predict its results
	task automatic send_item(input item_t it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tdata <= {{(64 - ITEM_W){1'b0}}, it};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		compute_bank_results(it);
	endtask

	// Drop valid, wait for every awaited result, then let silent work finish
	task automatic drain_bank();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_inv_code(input logic [7:0] code);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_INV_CODE;
		pwdata <= {8'(24'($urandom()) >> 16), 16'h0, code} & 32'h00FF_FFFF | {24'h0, code};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		inv_code = code;
	endtask

	task automatic test_after_reset();
		send_item(make_item(CMD_COLLECT, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_UNUSED, 7, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(make_item(CMD_START, 5, 0, 0, 0, 0));
	endtask

	task automatic test_allocation();
		repeat (NUM_TIMERS + 1)
			send_item(make_item(CMD_ALLOC, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_DEALLOC, 3, 0, 0, 0, 0));
		send_item(make_item(CMD_SETUP, 3, 5, 1, 8'h11, 8'h22));
	endtask

	task automatic test_setup_and_start();
		send_item(make_item(CMD_SETUP, 0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
		// zero period, no repeats: one expiry and stop
		send_item(make_item(CMD_SETUP, 1, 0, 0, 8'h5A, 8'hA5));
		// zero period, forever: expires on every tick
		send_item(make_item(CMD_SETUP, 2, 0, REPEAT_FOREVER, 8'h81, 8'h7E));
		// never set up, so the message type matches the invalid code
		send_item(make_item(CMD_START, 4, 0, 0, 0, 0));
		send_item(make_item(CMD_START, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_START, 1, 0, 0, 0, 0));
		send_item(make_item(CMD_START, 2, 0, 0, 0, 0));
	endtask

	task automatic test_expiry_and_collect();
		send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_COLLECT, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_STOP, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_DEALLOC, 2, 0, 0, 0, 0));
	endtask

	task automatic test_random_traffic();
		logic [7:0] codes [RANDOM_PHASES];
		codes[0] = 8'hFF;
		codes[1] = 8'($urandom_range(1, 254));
		codes[2] = 8'h00;
		codes[3] = 8'($urandom_range(0, 255));
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_bank();
			write_inv_code(codes[p]);
			// no idling on either side in the last phase
			if (p == RANDOM_PHASES - 1)
				calm = 1'b1;
			repeat (ITEMS_PER_PHASE)
				send_item(draw_random_item());
		end
	endtask

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (sink_wait > 0) begin
			sink_wait <= sink_wait - 1;
			m_tready <= (sink_wait == 1);
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			sink_wait <= $urandom_range(1, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Check each accepted result item against the oldest prediction
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'({m_tlast, m_tdata[RES_DATA_W-1:0]});
			if (awaited_results.size() == 0) begin
				$error("unexpected result item: status %0d, result_timer %0d",
					got.status, got.result_timer);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("status", want.status, got.status);
				compare_field("result_timer", want.result_timer, got.result_timer);
				compare_field("out_msg_type", want.out_msg_type, got.out_msg_type);
				compare_field("out_msg_options", want.out_msg_options, got.out_msg_options);
				compare_field("wake", want.wake, got.wake);
				compare_field("last", want.last, got.last);
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL repeating_timer_bank_unit");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_TIMERS; i++) begin
			owned[i] = 1'b0;
			running[i] = 1'b0;
			fired[i] = 1'b0;
			remaining[i] = '0;
			period[i] = '0;
			repeats[i] = '0;
			cb_type[i] = '0;
			cb_opts[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_inv_code(8'h00);
		test_after_reset();
		test_allocation();
		test_setup_and_start();
		test_expiry_and_collect();
		test_random_traffic();
		drain_bank();
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("PASS repeating_timer_bank_unit");
		else
			$display("FAIL repeating_timer_bank_unit");
		$finish;
	end

endmodule
